// File: rtl/tmt_pkg.sv
// Shared constants, types and address helpers for the text terminal core.
`timescale 1ns / 1ps

package tmt_pkg;

   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = ROWS * COLUMNS;
   localparam int ADDR_W  = $clog2(CELLS);

   localparam int ACT_W   = 3;
   localparam int CHAR_W  = 8;
   localparam int COLOR_W = 8;
   localparam int COL_W   = 7;
   localparam int ROW_W   = 5;
   localparam int CELL_W  = 16;

   localparam logic [CHAR_W-1:0]  CH_NEWLINE  = 8'd10;
   localparam logic [CHAR_W-1:0]  CH_SPACE    = 8'd32;
   localparam logic [COLOR_W-1:0] RESET_COLOR = 8'd79;

   localparam logic [ACT_W-1:0] ACT_PUT_CHAR   = 3'd0;
   localparam logic [ACT_W-1:0] ACT_SET_CURSOR = 3'd1;
   localparam logic [ACT_W-1:0] ACT_WRITE_CELL = 3'd2;
   localparam logic [ACT_W-1:0] ACT_CLEAR      = 3'd3;
   localparam logic [ACT_W-1:0] ACT_READ_CELL  = 3'd4;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_EXEC  = 6'b000010,
      ST_RDATA = 6'b000100,
      ST_FILL  = 6'b001000,
      ST_PUT   = 6'b010000,
      ST_HOLD  = 6'b100000
   } state_type;

   // Map a screen row to its place in the circular row store.
   function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] r,
                                                 input logic [ROW_W-1:0] base);
      logic [ROW_W:0] sum;
      sum = {1'b0, r} + {1'b0, base};
      if (sum >= (ROW_W+1)'(ROWS)) begin
         sum = sum - (ROW_W+1)'(ROWS);
      end
      return sum[ROW_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] row_start(input logic [ROW_W-1:0] prow);
      return ADDR_W'(ADDR_W'(prow) * ADDR_W'(COLUMNS));
   endfunction

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                   input logic [COL_W-1:0] c,
                                                   input logic [ROW_W-1:0] base);
      return ADDR_W'(row_start(phys_row(r, base)) + ADDR_W'(c));
   endfunction

endpackage

// File: rtl/tmt_if.sv
// Request and response channel interfaces for the text terminal core.
`timescale 1ns / 1ps

interface tmt_req_if;
   logic                          valid;
   logic                          ready;
   logic [tmt_pkg::ACT_W-1:0]     action;
   logic [tmt_pkg::CHAR_W-1:0]    char_code;
   logic [tmt_pkg::COLOR_W-1:0]   cell_color;
   logic [tmt_pkg::COL_W-1:0]     col;
   logic [tmt_pkg::ROW_W-1:0]     row;

   modport source (output valid, action, char_code, cell_color, col, row, input ready);
   modport sink   (input valid, action, char_code, cell_color, col, row, output ready);
endinterface

interface tmt_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tmt_pkg::CELL_W-1:0]    cell_value;
   logic [tmt_pkg::COL_W-1:0]     cursor_col;
   logic [tmt_pkg::ROW_W-1:0]     cursor_row;

   modport source (output valid, cell_value, cursor_col, cursor_row, input ready);
   modport sink   (input valid, cell_value, cursor_col, cursor_row, output ready);
endinterface

// File: rtl/text_mode_terminal_core.sv
// Text terminal core: circular row store in one RAM, cursor and scroll control.
//
//   port       dir   handshake      carries
//   req_chan   in    valid/ready    action, char_code, cell_color, col, row
//   rsp_chan   out   valid/ready    cell_value, cursor_col, cursor_row
//   csr_*      in    csr_we         csr_wdata -> text color
//
// Put char, set cursor, write cell and unused actions finish in ST_EXEC; read cell also passes ST_RDATA.
// A put char that scrolls clears the new bottom row in ST_FILL, then finishes in ST_PUT.
// Clear screen sweeps every cell in ST_FILL.
// After reset a sweep fills every RAM cell; no word is taken then.
// One response word is buffered; the next word is accepted while it waits.
`timescale 1ns / 1ps

module text_mode_terminal_core (
   input  logic                          clock,
   input  logic                          reset,
   tmt_req_if.sink                       req_chan,
   tmt_rsp_if.source                     rsp_chan,
   input  logic                          csr_we,
   input  logic [tmt_pkg::COLOR_W-1:0]   csr_wdata
);

   localparam logic [tmt_pkg::COL_W-1:0] COL_MAX = tmt_pkg::COL_W'(tmt_pkg::COLUMNS);
   localparam logic [tmt_pkg::ROW_W-1:0] ROW_LAST = tmt_pkg::ROW_W'(tmt_pkg::ROWS - 1);
   localparam logic [tmt_pkg::ADDR_W-1:0] ADDR_LAST = tmt_pkg::ADDR_W'(tmt_pkg::CELLS - 1);
   localparam logic [tmt_pkg::ADDR_W-1:0] ROW_SPAN = tmt_pkg::ADDR_W'(tmt_pkg::COLUMNS - 1);

   logic [tmt_pkg::CELL_W-1:0] mem [tmt_pkg::CELLS];

   tmt_pkg::state_type state_ff, state_in, nxt_ff, nxt_in;

   logic [tmt_pkg::ROW_W-1:0]   base_ff, base_in;
   logic [tmt_pkg::COL_W-1:0]   cur_col_ff, cur_col_in;
   logic [tmt_pkg::ROW_W-1:0]   cur_row_ff, cur_row_in;
   logic [tmt_pkg::COLOR_W-1:0] text_color_ff, text_color_in;
   logic [tmt_pkg::COLOR_W-1:0] fill_color_ff, fill_color_in;
   logic [tmt_pkg::ADDR_W-1:0]  fill_addr_ff, fill_addr_in;
   logic [tmt_pkg::ADDR_W-1:0]  fill_last_ff, fill_last_in;

   logic [tmt_pkg::ACT_W-1:0]   act_ff, act_in;
   logic [tmt_pkg::CHAR_W-1:0]  ch_ff, ch_in;
   logic [tmt_pkg::COLOR_W-1:0] attr_ff, attr_in;
   logic [tmt_pkg::COL_W-1:0]   col_ff, col_in;
   logic [tmt_pkg::ROW_W-1:0]   row_ff, row_in;

   logic [tmt_pkg::CELL_W-1:0]  val_ff, val_in;
   logic [tmt_pkg::CELL_W-1:0]  rd_data_ff;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [tmt_pkg::CELL_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [tmt_pkg::COL_W-1:0]   rsp_col_ff, rsp_col_in;
   logic [tmt_pkg::ROW_W-1:0]   rsp_row_ff, rsp_row_in;

   logic                        mem_we;
   logic [tmt_pkg::ADDR_W-1:0]  mem_waddr;
   logic [tmt_pkg::CELL_W-1:0]  mem_wdata;
   logic [tmt_pkg::ADDR_W-1:0]  mem_raddr;

   logic rsp_free;
   logic finish;
   logic wrap;
   logic in_range;

   assign req_chan.ready      = (state_ff == tmt_pkg::ST_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.cell_value = rsp_value_ff;
   assign rsp_chan.cursor_col = rsp_col_ff;
   assign rsp_chan.cursor_row = rsp_row_ff;

   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;
   assign wrap     = (cur_col_ff >= COL_MAX) || (ch_ff == tmt_pkg::CH_NEWLINE);
   assign in_range = (col_ff < COL_MAX) && (row_ff <= ROW_LAST);

   always_comb begin
      state_in      = state_ff;
      nxt_in        = nxt_ff;
      base_in       = base_ff;
      cur_col_in    = cur_col_ff;
      cur_row_in    = cur_row_ff;
      text_color_in = csr_we ? csr_wdata : text_color_ff;
      fill_color_in = fill_color_ff;
      fill_addr_in  = fill_addr_ff;
      fill_last_in  = fill_last_ff;
      act_in        = act_ff;
      ch_in         = ch_ff;
      attr_in       = attr_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      val_in        = val_ff;
      mem_we        = 1'b0;
      mem_waddr     = fill_addr_ff;
      mem_wdata     = {fill_color_ff, tmt_pkg::CH_SPACE};
      mem_raddr     = tmt_pkg::cell_addr(row_ff, col_ff, base_ff);
      finish        = 1'b0;

      case (state_ff)
         tmt_pkg::ST_IDLE: begin
            if (req_chan.valid) begin
               act_in   = req_chan.action;
               ch_in    = req_chan.char_code;
               attr_in  = req_chan.cell_color;
               col_in   = req_chan.col;
               row_in   = req_chan.row;
               state_in = tmt_pkg::ST_EXEC;
            end
         end
         tmt_pkg::ST_EXEC: begin
            val_in = '0;
            case (act_ff)
               tmt_pkg::ACT_PUT_CHAR: begin
                  if (wrap && cur_row_ff >= ROW_LAST) begin
                     // scroll: advance the row base, then blank the old top row
                     base_in       = (base_ff == ROW_LAST) ? '0 : base_ff + 1'b1;
                     cur_col_in    = '0;
                     fill_addr_in  = tmt_pkg::row_start(base_ff);
                     fill_last_in  = tmt_pkg::row_start(base_ff) + ROW_SPAN;
                     fill_color_in = text_color_ff;
                     nxt_in        = tmt_pkg::ST_PUT;
                     state_in      = tmt_pkg::ST_FILL;
                  end else begin
                     if (wrap) begin
                        cur_col_in = '0;
                        cur_row_in = cur_row_ff + 1'b1;
                     end
                     if (ch_ff != tmt_pkg::CH_NEWLINE) begin
                        mem_we     = 1'b1;
                        mem_waddr  = tmt_pkg::cell_addr(cur_row_in, cur_col_in, base_ff);
                        mem_wdata  = {text_color_ff, ch_ff};
                        cur_col_in = cur_col_in + 1'b1;
                     end
                     finish = 1'b1;
                  end
               end
               tmt_pkg::ACT_SET_CURSOR: begin
                  cur_col_in = (col_ff > COL_MAX) ? COL_MAX : col_ff;
                  cur_row_in = (row_ff > ROW_LAST) ? ROW_LAST : row_ff;
                  finish     = 1'b1;
               end
               tmt_pkg::ACT_WRITE_CELL: begin
                  if (in_range) begin
                     mem_we    = 1'b1;
                     mem_waddr = tmt_pkg::cell_addr(row_ff, col_ff, base_ff);
                     mem_wdata = {attr_ff, ch_ff};
                  end
                  finish = 1'b1;
               end
               tmt_pkg::ACT_CLEAR: begin
                  fill_addr_in  = '0;
                  fill_last_in  = ADDR_LAST;
                  fill_color_in = text_color_ff;
                  nxt_in        = tmt_pkg::ST_HOLD;
                  state_in      = tmt_pkg::ST_FILL;
               end
               tmt_pkg::ACT_READ_CELL: begin
                  if (in_range) begin
                     state_in = tmt_pkg::ST_RDATA;
                  end else begin
                     finish = 1'b1;
                  end
               end
               default: begin
                  finish = 1'b1;
               end
            endcase
         end
         tmt_pkg::ST_RDATA: begin
            val_in = rd_data_ff;
            finish = 1'b1;
         end
         tmt_pkg::ST_FILL: begin
            mem_we = 1'b1;
            if (fill_addr_ff == fill_last_ff) begin
               state_in = nxt_ff;
            end else begin
               fill_addr_in = fill_addr_ff + 1'b1;
            end
         end
         tmt_pkg::ST_PUT: begin
            if (ch_ff != tmt_pkg::CH_NEWLINE) begin
               mem_we     = 1'b1;
               mem_waddr  = tmt_pkg::cell_addr(cur_row_ff, cur_col_ff, base_ff);
               mem_wdata  = {text_color_ff, ch_ff};
               cur_col_in = cur_col_ff + 1'b1;
            end
            finish = 1'b1;
         end
         tmt_pkg::ST_HOLD: begin
            finish = 1'b1;
         end
         default: begin
            state_in = tmt_pkg::ST_IDLE;
         end
      endcase

      // hand the result to the output register, or hold it until the slot drains
      if (finish) begin
         state_in = rsp_free ? tmt_pkg::ST_IDLE : tmt_pkg::ST_HOLD;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_value_in = rsp_value_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      if (finish && rsp_free) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = val_in;
         rsp_col_in   = cur_col_in;
         rsp_row_in   = cur_row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tmt_pkg::ST_FILL;
         nxt_ff        <= tmt_pkg::ST_IDLE;
         base_ff       <= '0;
         cur_col_ff    <= '0;
         cur_row_ff    <= '0;
         text_color_ff <= tmt_pkg::RESET_COLOR;
         fill_color_ff <= tmt_pkg::RESET_COLOR;
         fill_addr_ff  <= '0;
         fill_last_ff  <= ADDR_LAST;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         nxt_ff        <= nxt_in;
         base_ff       <= base_in;
         cur_col_ff    <= cur_col_in;
         cur_row_ff    <= cur_row_in;
         text_color_ff <= text_color_in;
         fill_color_ff <= fill_color_in;
         fill_addr_ff  <= fill_addr_in;
         fill_last_ff  <= fill_last_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff       <= act_in;
      ch_ff        <= ch_in;
      attr_ff      <= attr_in;
      col_ff       <= col_in;
      row_ff       <= row_in;
      val_ff       <= val_in;
      rsp_value_ff <= rsp_value_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_row_ff   <= rsp_row_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

endmodule
